// ===== design/lrs_pkg.sv =====
// shared constants and codes for the range-add / range-sum tree
package lrs_pkg;

  localparam int unsigned PosW      = 10;
  localparam int unsigned ValW      = 32;
  localparam int unsigned SumW      = 64;
  localparam int unsigned DefLeaves = 1024;

  localparam logic FuncAdd = 1'b0;
  localparam logic FuncSum = 1'b1;

endpackage

// ===== design/lrs_mem.sv =====
// two synchronous single-read single-write memories for the slope and offset trees
module lrs_mem #(
  parameter int unsigned Leaves = lrs_pkg::DefLeaves,
  parameter int unsigned AddrW  = $clog2(Leaves + 1)
) (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [AddrW-1:0]          rd_addr_i,
  input  logic                      wr_en_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [lrs_pkg::SumW-1:0]  wr_slope_i,
  input  logic [lrs_pkg::SumW-1:0]  wr_offset_i,
  output logic [lrs_pkg::SumW-1:0]  rd_slope_o,
  output logic [lrs_pkg::SumW-1:0]  rd_offset_o
);
  import lrs_pkg::*;

  logic [SumW-1:0] slope_mem  [Leaves+1];
  logic [SumW-1:0] offset_mem [Leaves+1];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      slope_mem[wr_addr_i]  <= wr_slope_i;
      offset_mem[wr_addr_i] <= wr_offset_i;
    end
    if (rd_en_i) begin
      rd_slope_o  <= slope_mem[rd_addr_i];
      rd_offset_o <= offset_mem[rd_addr_i];
    end
  end

endmodule

// ===== design/lazy_range_add_range_sum_tree_unit.sv =====
// Range add / range sum over Leaves positions, all positions zero after reset.
// Input channel: in_valid_i / in_stall_o with func_i, range_low_i, range_high_i,
// add_value_i. func_i add: adds add_value_i to every position of the range and
// gives no result. func_i sum: gives one range_sum_o on the output channel
// out_valid_o / out_stall_i. Empty ranges (low > high or low >= Leaves) add
// nothing and sum to 0; high is clipped to Leaves-1. Sums wrap in 64 bits.
// State lives in two binary indexed trees (slope and offset) in one pair of
// memories sharing a read and a write port. An add walks up from two points,
// with a read state and then a write state per node. A sum walks down from
// two prefixes, with a read state and an accumulate state per node, plus the
// multiply states StMulLo and StMulHi per prefix. An empty add stays idle and
// an empty sum goes straight to StOut. One item is in work at a time. After
// reset the memories are cleared, all Leaves+1 addresses, with in_stall_o
// high. A finished sum sits in the output register while the next item is
// taken; if out_stall_i still holds it when the next sum finishes, that sum
// waits.
module lazy_range_add_range_sum_tree_unit #(
  parameter int unsigned Leaves = lrs_pkg::DefLeaves
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                func_i,
  input  logic [lrs_pkg::PosW-1:0]            range_low_i,
  input  logic [lrs_pkg::PosW-1:0]            range_high_i,
  input  logic signed [lrs_pkg::ValW-1:0]     add_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [lrs_pkg::SumW-1:0]     range_sum_o
);
  import lrs_pkg::*;

  localparam int unsigned AW = $clog2(Leaves + 1);
  localparam int unsigned CW = $clog2(Leaves) + 2;
  localparam int unsigned PW = CW + 34;
  localparam logic [CW-1:0] LeavesC = CW'(Leaves);
  localparam logic [31:0]   LastPos = 32'(Leaves - 1);

  typedef enum logic [3:0] {
    StClear, StIdle, StAddMul, StAddRd, StAddWr,
    StSumRd, StSumAcc, StMulLo, StMulHi, StOut
  } state_e;

  state_e            state_q;
  logic [AW-1:0]     clr_q;
  logic              pass_q;
  logic [CW-1:0]     a_q, b_q, x_q, idx_q;
  logic [ValW-1:0]   v_q;
  logic [SumW-1:0]   d1_q, d2_q, acc1_q, acc2_q, pacc_q, res_q, out_q;
  logic              out_valid_q;

  logic              in_acc;
  logic [31:0]       a32, b32, bclip32;
  logic              empty;
  logic [CW-1:0]     lowbit;
  logic signed [32:0]    mul_a;
  logic signed [PW-1:0]  mul_p;
  logic [SumW-1:0]   mul_w, prefix, vext;

  logic              rd_en, wr_en;
  logic [AW-1:0]     wr_addr;
  logic [SumW-1:0]   rd1, rd2, wr1, wr2;

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign range_sum_o = out_q;

  assign a32     = 32'(range_low_i);
  assign b32     = 32'(range_high_i);
  assign empty   = (a32 > b32) || (a32 >= 32'(Leaves));
  assign bclip32 = (b32 > LastPos) ? LastPos : b32;
  assign lowbit  = idx_q & (~idx_q + CW'(1));
  assign vext    = SumW'(signed'(v_q));

  // one shared multiplier: value times index, or prefix slope times position
  always_comb begin
    case (state_q)
      StMulLo: mul_a = {1'b0, acc1_q[31:0]};
      StMulHi: mul_a = {1'b0, acc1_q[63:32]};
      default: mul_a = {v_q[ValW-1], v_q};
    endcase
  end
  assign mul_p  = mul_a * $signed({1'b0, x_q});
  assign mul_w  = SumW'(mul_p);
  assign prefix = pacc_q + {mul_w[31:0], 32'b0} - acc2_q;

  assign rd_en   = ((state_q == StAddRd) && (idx_q <= LeavesC)) ||
                   ((state_q == StSumRd) && (idx_q != '0));
  assign wr_en   = (state_q == StClear) || (state_q == StAddWr);
  assign wr_addr = (state_q == StClear) ? clr_q : idx_q[AW-1:0];
  assign wr1     = (state_q == StClear) ? '0 : rd1 + d1_q;
  assign wr2     = (state_q == StClear) ? '0 : rd2 + d2_q;

  lrs_mem #(
    .Leaves (Leaves),
    .AddrW  (AW)
  ) u_mem (
    .clk_i       (clk_i),
    .rd_en_i     (rd_en),
    .rd_addr_i   (idx_q[AW-1:0]),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_slope_i  (wr1),
    .wr_offset_i (wr2),
    .rd_slope_o  (rd1),
    .rd_offset_o (rd2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == StOut) && (!out_valid_q || !out_stall_i)) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(Leaves)) state_q <= StIdle;
        end
        StIdle: begin
          if (in_acc) begin
            v_q    <= add_value_i;
            a_q    <= CW'(a32);
            b_q    <= CW'(bclip32);
            pass_q <= 1'b0;
            if (func_i == FuncAdd) begin
              if (!empty) begin
                x_q     <= CW'(a32);
                state_q <= StAddMul;
              end
            end else if (empty) begin
              res_q   <= '0;
              state_q <= StOut;
            end else begin
              x_q     <= CW'(bclip32) + CW'(1);
              idx_q   <= CW'(bclip32) + CW'(1);
              acc1_q  <= '0;
              acc2_q  <= '0;
              state_q <= StSumRd;
            end
          end
        end
        StAddMul: begin
          // first point gets +v and +v*low, second gets -v and -v*(high+1)
          d1_q    <= pass_q ? -vext : vext;
          d2_q    <= pass_q ? -mul_w : mul_w;
          idx_q   <= x_q + CW'(1);
          state_q <= StAddRd;
        end
        StAddRd: begin
          if (idx_q > LeavesC) begin
            if (!pass_q) begin
              pass_q  <= 1'b1;
              x_q     <= b_q + CW'(1);
              state_q <= StAddMul;
            end else begin
              state_q <= StIdle;
            end
          end else begin
            state_q <= StAddWr;
          end
        end
        StAddWr: begin
          idx_q   <= idx_q + lowbit;
          state_q <= StAddRd;
        end
        StSumRd: begin
          state_q <= (idx_q == '0) ? StMulLo : StSumAcc;
        end
        StSumAcc: begin
          acc1_q  <= acc1_q + rd1;
          acc2_q  <= acc2_q + rd2;
          idx_q   <= idx_q - lowbit;
          state_q <= StSumRd;
        end
        StMulLo: begin
          pacc_q  <= mul_w;
          state_q <= StMulHi;
        end
        StMulHi: begin
          if (!pass_q) begin
            res_q   <= prefix;
            pass_q  <= 1'b1;
            x_q     <= a_q;
            idx_q   <= a_q;
            acc1_q  <= '0;
            acc2_q  <= '0;
            state_q <= StSumRd;
          end else begin
            res_q   <= res_q - prefix;
            state_q <= StOut;
          end
        end
        StOut: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res_q;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_sum_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && func_i == FuncSum) |=> in_stall_o)
    else $error("sum transaction did not hold the input side");

  a_wr_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StAddWr) |-> (idx_q != '0) && (idx_q <= LeavesC))
    else $error("tree write outside node range");

  a_up_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StAddWr) |=> (idx_q > $past(idx_q)))
    else $error("update walk did not climb");

  a_down_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSumAcc) |=> (idx_q < $past(idx_q)))
    else $error("prefix walk did not descend");
`endif

endmodule

// ===== tb/range_sum_checker.sv =====
// checker: predicts range sums from observed add and sum transactions
`timescale 1ns / 100ps

module range_sum_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic                               func_i,
  input  logic [lrs_pkg::PosW-1:0]           range_low_i,
  input  logic [lrs_pkg::PosW-1:0]           range_high_i,
  input  logic signed [lrs_pkg::ValW-1:0]    add_value_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic signed [lrs_pkg::SumW-1:0]    range_sum_i,
  output int                                 fail_count_o,
  output int                                 sums_pending_o
);
  import lrs_pkg::*;

  localparam int unsigned Leaves = DefLeaves;

  // flat array of positions is enough to predict the tree exactly
  logic [SumW-1:0] position_value [Leaves];
  logic [SumW-1:0] expected_sums [$];

  function automatic logic [SumW-1:0] sum_positions(int unsigned lo, int unsigned hi);
    logic [SumW-1:0] acc;
    acc = '0;
    for (int unsigned p = lo; p <= hi; p++) acc += position_value[p];
    return acc;
  endfunction

  task automatic apply_transaction(logic fn, int unsigned lo, int unsigned hi,
                                   logic signed [ValW-1:0] amount);
    logic empty_range;
    logic [SumW-1:0] ext;
    logic [SumW-1:0] predicted;
    empty_range = (lo > hi) || (lo >= Leaves);
    if (!empty_range && hi > Leaves - 1) hi = Leaves - 1;
    ext = SumW'(amount);
    if (fn == FuncAdd) begin
      if (!empty_range)
        for (int unsigned p = lo; p <= hi; p++) position_value[p] += ext;
    end else begin
      predicted = empty_range ? '0 : sum_positions(lo, hi);
      expected_sums.insert(expected_sums.size(), predicted);
    end
  endtask

  initial begin
    fail_count_o = 0;
    for (int p = 0; p < Leaves; p++) position_value[p] = '0;
  end

  assign sums_pending_o = expected_sums.size();

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_sums.size() == 0) begin
          $error("range_sum: unexpected result %0d", range_sum_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          if (range_sum_i !== expected_sums[0]) begin
            $error("range_sum: expected %0d actual %0d",
                   $signed(expected_sums[0]), range_sum_i);
            fail_count_o <= fail_count_o + 1;
          end
          void'(expected_sums.pop_front());
        end
      end
      if (in_valid_i && !in_stall_i)
        apply_transaction(func_i, range_low_i, range_high_i, add_value_i);
    end
  end

endmodule

// ===== tb/testbench.sv =====
// top: stimulus for the range-add / range-sum tree and the final verdict
`timescale 1ns / 100ps

module testbench;
  import lrs_pkg::*;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     func_i;
  logic [PosW-1:0]          range_low_i;
  logic [PosW-1:0]          range_high_i;
  logic signed [ValW-1:0]   add_value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [SumW-1:0]   range_sum_o;
  int                       fail_count;
  int                       sums_pending;
  bit                       calm_phase;

  lazy_range_add_range_sum_tree_unit u_dut (.*);

  range_sum_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .func_i, .range_low_i,
    .range_high_i, .add_value_i, .out_valid_i(out_valid_o), .out_stall_i,
    .range_sum_i(range_sum_o), .fail_count_o(fail_count), .sums_pending_o(sums_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver stalls in bursts, except in the calm phase
  initial begin
    int burst;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (burst > 0) begin
        burst--;
        out_stall_i <= 1'b1;
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // one transaction: hold until accepted, then maybe idle a burst
  task automatic send_item(logic fn, logic [PosW-1:0] lo, logic [PosW-1:0] hi,
                           logic signed [ValW-1:0] amount);
    int gap;
    in_valid_i   <= 1'b1;
    func_i       <= fn;
    range_low_i  <= lo;
    range_high_i <= hi;
    add_value_i  <= amount;
    do @(posedge clk_i); while (in_stall_o);
    if (!calm_phase && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // mostly short ranges, sometimes wide or empty
  task automatic send_random_item();
    logic [PosW-1:0] lo, hi;
    logic signed [ValW-1:0] amount;
    int kind;
    kind = $urandom_range(0, 9);
    lo = PosW'($urandom);
    if (kind < 6) hi = PosW'(32'(lo) + $urandom_range(0, 40));
    else if (kind < 9) hi = PosW'($urandom);
    else hi = lo - PosW'($urandom_range(1, 5));
    amount = ($urandom_range(0, 3) == 0) ? ValW'($urandom)
                                         : ValW'(int'($urandom_range(0, 2000)) - 1000);
    send_item($urandom_range(0, 1) ? FuncSum : FuncAdd, lo, hi, amount);
  endtask

  initial begin
    in_valid_i   = 1'b0;
    func_i       = FuncAdd;
    range_low_i  = '0;
    range_high_i = '0;
    add_value_i  = '0;
    calm_phase   = 1'b0;
    rst_ni       = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, empty ranges, wrapping
    send_item(FuncSum, 0, 1023, 0);
    send_item(FuncAdd, 0, 1023, 32'sh7fffffff);
    send_item(FuncSum, 0, 1023, 0);
    send_item(FuncAdd, 0, 1023, 32'sh7fffffff);
    send_item(FuncAdd, 0, 1023, 32'sh7fffffff);
    send_item(FuncSum, 0, 1023, 0);
    send_item(FuncAdd, 1023, 1023, 32'sh80000000);
    send_item(FuncAdd, 0, 0, -1);
    send_item(FuncSum, 0, 0, 32'shffffffff);
    send_item(FuncSum, 1023, 1023, 0);
    send_item(FuncAdd, 5, 4, 12345);
    send_item(FuncSum, 5, 4, 0);
    send_item(FuncSum, 1023, 0, 0);
    send_item(FuncAdd, 300, 700, 32'sh55555555);
    send_item(FuncAdd, 511, 512, 32'shaaaaaaaa);
    send_item(FuncSum, 0, 511, 0);
    send_item(FuncSum, 512, 1023, 0);
    send_item(FuncSum, 299, 701, 0);
    send_item(FuncSum, 10'h155, 10'h2aa, 0);
    send_item(FuncSum, 10'h2aa, 10'h3ff, 0);

    // hold off until every outstanding sum has drained
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sums_pending != 0) @(posedge clk_i);

    for (int n = 0; n < 950; n++) begin
      if (n == 800) calm_phase = 1'b1;
      send_random_item();
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (sums_pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
